FILE: rtl/core/record_sort_by_modular_sum_macros.svh
// Assertion macros shared by the record sorter.
`ifndef RECORD_SORT_BY_MODULAR_SUM_MACROS_SVH
`define RECORD_SORT_BY_MODULAR_SUM_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define RSMS_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define RSMS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rsms_pkg.sv
`default_nettype none
package rsms_pkg;
  localparam int MaxRecords = 16;
  localparam int MaxElements = 48;
  localparam int ResultCap = 64;
  localparam int RecW = $clog2(MaxRecords);
  localparam int RecCntW = $clog2(MaxRecords + 1);
  localparam int ElemW = $clog2(MaxElements);
  localparam int ElemCntW = $clog2(MaxElements + 1);
  localparam int ResCntW = $clog2(ResultCap + 1);
  localparam int ValW = 31;
  localparam logic [ValW-1:0] ModulusReset = 31'd1000000007;

  typedef struct packed {
    logic [ValW-1:0] element;
    logic element_present;
    logic end_of_record;
    logic end_of_set;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [ValW-1:0] value;
    logic record_done;
    logic last;
    logic overflow;
  } out_item_t;

  // Record descriptor carried along the sorting chain.
  typedef struct packed {
    logic valid;
    logic [ValW-1:0] key;
    logic [ElemW-1:0] start;
    logic [ElemCntW-1:0] len;
  } rec_t;

  localparam logic KindKey = 1'b0;
  localparam logic KindElem = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/rsms_cell.sv
`default_nettype none
// One insertion cell: keeps the smallest record it has seen, passes the rest on.
// Equal keys fall back to load position (start, then length), so records with
// equal keys leave the chain in load order whatever order they reach a cell.
module rsms_cell import rsms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic clear,
  input  wire logic shift,
  input  wire rec_t in_rec,
  output rec_t      out_rec,
  output rec_t      held
);
  rec_t held_r, held_nxt, out_r, out_nxt;

  always_comb begin
    held_nxt = held_r;
    out_nxt = '0;
    if (clear) begin
      held_nxt = '0;
    end else if (shift) begin
      // Pull the neighbor's held record; nothing is passed on downstream.
      held_nxt = in_rec;
    end else if (in_rec.valid) begin
      if (!held_r.valid) begin
        held_nxt = in_rec;
      end else if ({in_rec.key, in_rec.start, in_rec.len} <
                   {held_r.key, held_r.start, held_r.len}) begin
        held_nxt = in_rec;
        out_nxt = held_r;
      end else begin
        out_nxt = in_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      out_r <= '0;
    end else begin
      held_r <= held_nxt;
      out_r <= shift ? '0 : out_nxt;
    end
  end

  assign out_rec = out_r;
  assign held = held_r;
endmodule
`default_nettype wire

FILE: rtl/core/rsms_modsum.sv
`default_nettype none
`include "record_sort_by_modular_sum_macros.svh"
// Running sum step: sum = (sum + e mod m) mod m, or sum + e when m is zero; one quotient bit a cycle.
module rsms_modsum import rsms_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [ValW-1:0] elem,
  input  wire logic [ValW-1:0] sum,
  input  wire logic [ValW-1:0] modulus,
  output logic                 busy,
  output logic                 done,
  output logic [ValW-1:0]      result
);
  localparam int CntW = $clog2(ValW + 1);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ADD} state_t;
  state_t state_r;
  logic [CntW-1:0] cnt_r;
  logic [ValW:0] rem_r;
  logic [ValW-1:0] quo_r, res_r, sum_r;
  logic done_r;
  logic [ValW:0] trial, rem_sh, tot;

  always_comb begin
    rem_sh = {rem_r[ValW-1:0], quo_r[ValW-1]};
    trial = rem_sh - {1'b0, modulus};
    tot = {1'b0, rem_r[ValW-1:0]} + {1'b0, sum_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            quo_r <= elem;
            rem_r <= '0;
            sum_r <= sum;
            cnt_r <= CntW'(ValW);
            if (modulus == '0) begin
              res_r <= sum + elem;
              done_r <= 1'b1;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo_r <= {quo_r[ValW-2:0], 1'b0};
          rem_r <= trial[ValW] ? rem_sh : trial;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CntW'(1)) state_r <= S_ADD;
        end
        S_ADD: begin
          // Sum is below the modulus and so is the remainder: one subtract.
          res_r <= (tot >= {1'b0, modulus}) ? ValW'(tot - {1'b0, modulus})
                                             : tot[ValW-1:0];
          done_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign result = res_r;

  `RSMS_ASSERT_NEXT(a_add_done, clk, rst_n, state_r == S_ADD, done_r, "add without done")
  `RSMS_ASSERT_IMPLY(a_cnt_idle, clk, rst_n, state_r == S_DIV, cnt_r != '0, "div count zero")
  `RSMS_ASSERT_IMPLY(a_no_start_busy, clk, rst_n, busy, !done_r, "done while busy")
endmodule
`default_nettype wire

FILE: rtl/core/record_sort_by_modular_sum.sv
`default_nettype none
`include "record_sort_by_modular_sum_macros.svh"
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | in_item  (in_item_t)
// out_    | output    | out_valid / out_stall | out_item (out_item_t)
// cfg_    | input     | cfg_we                | cfg_data (modulus, 31 bits)
//
// An element transaction starts the remainder unit, runs 31 shift-subtract
// steps and one add-and-reduce step (neither with a zero modulus), then takes
// the key and closes. Flag-only and dropped-element transactions go to close.
// At end of set: feed the chain, let it settle, then emit each key and its
// elements, each element from a registered memory read.
// out_stall holds the current result; reset (rst_n, synchronous) clears
// control state and restores the modulus.
module record_sort_by_modular_sum import rsms_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_item,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_item,
  input  wire logic            cfg_we,
  input  wire logic [ValW-1:0] cfg_data
);
  typedef enum logic [2:0] {
    S_LOAD, S_MOD, S_CLOSE, S_FEED, S_SETTLE, S_HEAD, S_EMIT
  } state_t;

  state_t state_r;
  logic [ValW-1:0] modulus_r;
  // Element memory and per-record descriptors.
  logic [ValW-1:0] elem_mem [MaxElements];
  rec_t rec_r [MaxRecords];

  logic [ValW-1:0] sum_r;
  logic [RecCntW-1:0] nrec_r, feed_r;
  logic [ElemCntW-1:0] nelem_r, cur_len_r;
  logic drop_r;
  in_item_t item_r;
  logic [RecCntW:0] settle_r;
  logic [ResCntW-1:0] nres_r;
  logic [ElemCntW-1:0] ecnt_r;
  rec_t cur_r;
  logic [ValW-1:0] rd_r;
  logic rd_vld_r;
  logic out_valid_r;
  out_item_t out_r;

  // Modular adder.
  logic ms_start, ms_busy, ms_done;
  logic [ValW-1:0] ms_res;

  rsms_modsum u_mod (
    .clk(clk), .rst_n(rst_n), .start(ms_start), .elem(item_r.element),
    .sum(sum_r), .modulus(modulus_r), .busy(ms_busy), .done(ms_done),
    .result(ms_res)
  );

  // Sorting chain.
  logic chain_clear, chain_shift;
  rec_t cell_src [MaxRecords];
  rec_t chain_out [MaxRecords];
  rec_t chain_held [MaxRecords];
  rec_t head;

  genvar g;
  generate
    for (g = 0; g < MaxRecords; g++) begin : g_cell
      rsms_cell u_cell (
        .clk(clk), .rst_n(rst_n), .clear(chain_clear), .shift(chain_shift),
        .in_rec(cell_src[g]), .out_rec(chain_out[g]), .held(chain_held[g])
      );
    end
  endgenerate

  // Cell 0 is fed from the descriptor table while loading the chain.
  rec_t feed_rec;
  always_comb begin
    feed_rec = '0;
    if (state_r == S_FEED && feed_r < nrec_r) feed_rec = rec_r[RecW'(feed_r)];
  end
  assign head = chain_held[0];

  // In shift mode cell g reads cell g+1's held record instead of the pass-on.
  always_comb begin
    for (int i = 0; i < MaxRecords; i++) begin
      cell_src[i] = '0;
      if (chain_shift) begin
        if (i < MaxRecords - 1) cell_src[i] = chain_held[(i + 1) % MaxRecords];
      end else if (i == 0) begin
        cell_src[i] = feed_rec;
      end else begin
        cell_src[i] = chain_out[(i + MaxRecords - 1) % MaxRecords];
      end
    end
  end

  logic in_ok;
  assign in_ok = in_valid && !in_stall;
  assign in_stall = (state_r != S_LOAD);
  assign ms_start = (state_r == S_MOD) && !ms_busy && !ms_done && !item_r.element_present;
  assign chain_clear = 1'b0;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic [ElemW-1:0] rd_addr;
  assign rd_addr = ElemW'(cur_r.start + ElemW'(ecnt_r));

  // Shift the chain as each record's key is taken.
  assign chain_shift = (state_r == S_HEAD) && out_free && head.valid &&
                       (nres_r != ResCntW'(ResultCap));

  // Emit an element once its registered read has landed.
  logic emit_elem;
  assign emit_elem = (state_r == S_EMIT) && out_free && rd_vld_r &&
                     (ecnt_r < cur_r.len) && (nres_r != ResCntW'(ResultCap));

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_ok && in_item.element_present &&
        nrec_r < RecCntW'(MaxRecords) && nelem_r < ElemCntW'(MaxElements)) begin
      elem_mem[ElemW'(nelem_r)] <= in_item.element;
    end
    rd_r <= elem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      modulus_r <= ModulusReset;
      sum_r <= '0;
      nrec_r <= '0;
      nelem_r <= '0;
      cur_len_r <= '0;
      drop_r <= 1'b0;
      feed_r <= '0;
      settle_r <= '0;
      nres_r <= '0;
      ecnt_r <= '0;
      rd_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
      item_r <= '0;
      for (int i = 0; i < MaxRecords; i++) rec_r[i] <= '0;
    end else begin
      if (cfg_we) modulus_r <= cfg_data;
      // Hold a stalled result; raise valid for each new key or element.
      out_valid_r <= chain_shift || emit_elem || (out_valid_r && out_stall);
      unique case (state_r)
        S_LOAD: begin
          if (in_ok) begin
            // Keep the flags; the element is either taken here or dropped.
            item_r <= '{element: in_item.element, element_present: 1'b0,
                        end_of_record: in_item.end_of_record,
                        end_of_set: in_item.end_of_set};
            if (in_item.element_present) begin
              if (nrec_r >= RecCntW'(MaxRecords) ||
                  nelem_r >= ElemCntW'(MaxElements)) begin
                drop_r <= 1'b1;
                state_r <= S_CLOSE;
              end else begin
                nelem_r <= nelem_r + 1'b1;
                cur_len_r <= cur_len_r + 1'b1;
                state_r <= S_MOD;
              end
            end else begin
              state_r <= S_CLOSE;
            end
          end
        end
        S_MOD: begin
          if (ms_done) begin
            sum_r <= ms_res;
            state_r <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          state_r <= S_LOAD;
          if (item_r.end_of_record || item_r.end_of_set) begin
            if (nrec_r < RecCntW'(MaxRecords)) begin
              rec_r[RecW'(nrec_r)] <= '{valid: 1'b1, key: sum_r,
                start: ElemW'(nelem_r - cur_len_r), len: cur_len_r};
              nrec_r <= nrec_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
            sum_r <= '0;
            cur_len_r <= '0;
          end
          if (item_r.end_of_set) begin
            feed_r <= '0;
            state_r <= S_FEED;
          end
        end
        S_FEED: begin
          feed_r <= feed_r + 1'b1;
          if (feed_r == nrec_r) begin
            settle_r <= '0;
            state_r <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          settle_r <= settle_r + 1'b1;
          if (settle_r == (RecCntW+1)'(MaxRecords)) begin
            nres_r <= '0;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (out_free) begin
            cur_r <= head;
            ecnt_r <= '0;
            rd_vld_r <= 1'b0;
            if (!head.valid || nres_r == ResCntW'(ResultCap)) begin
              // Run complete: clear load state.
              nrec_r <= '0;
              nelem_r <= '0;
              drop_r <= 1'b0;
              for (int i = 0; i < MaxRecords; i++) rec_r[i].valid <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              out_r.kind <= KindKey;
              out_r.value <= head.key;
              out_r.record_done <= (head.len == '0);
              out_r.overflow <= drop_r;
              out_r.last <= (nres_r == ResCntW'(ResultCap - 1)) ||
                            (head.len == '0 && !chain_held[1].valid);
              nres_r <= nres_r + 1'b1;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (ecnt_r >= cur_r.len || nres_r == ResCntW'(ResultCap)) begin
            state_r <= S_HEAD;
          end else if (!rd_vld_r) begin
            // Let the registered memory read of this element land first.
            rd_vld_r <= 1'b1;
          end else if (emit_elem) begin
            out_r.kind <= KindElem;
            out_r.value <= rd_r;
            out_r.record_done <= (ecnt_r + 1'b1 == cur_r.len);
            out_r.overflow <= drop_r;
            out_r.last <= (nres_r == ResCntW'(ResultCap - 1)) ||
                          (ecnt_r + 1'b1 == cur_r.len && !chain_held[0].valid);
            nres_r <= nres_r + 1'b1;
            ecnt_r <= ecnt_r + 1'b1;
            rd_vld_r <= 1'b0;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

  logic unused_ok;
  assign unused_ok = ^{chain_out[MaxRecords - 1]};

  `RSMS_ASSERT_IMPLY(a_stall_busy, clk, rst_n, state_r != S_LOAD, in_stall, "busy not stalled")
  `RSMS_ASSERT_IMPLY(a_nrec_cap, clk, rst_n, 1'b1, nrec_r <= RecCntW'(MaxRecords), "nrec over")
  `RSMS_ASSERT_IMPLY(a_nelem_cap, clk, rst_n, 1'b1, nelem_r <= ElemCntW'(MaxElements), "nelem over")
  `RSMS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "held")
endmodule
`default_nettype wire
